FILE: rtl/smas_pkg.sv
// Shared types and constants for the sorted MAC address set.
`timescale 1ns / 1ps

package smas_pkg;

    // Field widths.
    localparam int MAC_W       = 48;
    localparam int OPCODE_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Default number of table entries.
    localparam int CAPACITY_DEF = 64;

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    // Status codes.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One input transfer.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [MAC_W-1:0]    mac_address;
    } item_t;

    // One result transfer.
    typedef struct packed {
        logic                   found;
        logic                   status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic             shift_en;
        logic [MAC_W-1:0] key;
    } cell_ctl_t;

endpackage

FILE: rtl/smas_cell.sv
// One cell of the sorted chain: holds one address and compares it to the key.
`timescale 1ns / 1ps

module smas_cell (
    input  logic                     clk,
    input  smas_pkg::cell_ctl_t      ctl,
    input  logic                     valid,
    input  logic                     prev_le,
    input  logic [smas_pkg::MAC_W-1:0] prev_entry,
    output logic                     le,
    output logic                     eq,
    output logic [smas_pkg::MAC_W-1:0] entry
);
    import smas_pkg::*;

    logic [MAC_W-1:0] entry_reg;
    logic [MAC_W-1:0] entry_next;

    // Compare the stored address against the broadcast key.
    assign le    = valid && (entry_reg <= ctl.key);
    assign eq    = valid && (entry_reg == ctl.key);
    assign entry = entry_reg;

    // On an insert, a cell above the insertion point takes its lower
    // neighbor's entry, and the cell at the insertion point takes the key.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_en && !le)
        begin
            entry_next = prev_le ? ctl.key : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/sorted_mac_address_set_top.sv
// Sorted MAC address set: a chain of compare-and-shift cells with a sequencer.
`timescale 1ns / 1ps

// Usage:
// Items arrive on the item channel (item_valid, item_stall, item) and carry
// an opcode (lookup, insert, clear) and a 48-bit address. Each item gives
// exactly one transfer on the result channel (result_valid, result_stall,
// result) holding found, status and the entry count after the item.
// An accepted item is held in the opcode and key registers while the
// sequencer is in its execute state; there it is compared against every
// cell of the chain once the result register is free, and on an insert all
// cells above the insertion point shift up by one in that same cycle. The
// result is registered out of that execute step. A new item is not taken
// until the last one has finished its single compare-and-shift step of the
// cell chain; item_stall is high while an item is being worked on.
// If result_stall holds a finished result, the next item waits in the
// sequencer until the result register frees up, so nothing is lost.
// Reset clears the entry count and the handshake state; the cell contents
// are not cleared and are never read before they are written. An insert
// into a full table leaves the table as is and reports status full.

module sorted_mac_address_set_top #(
    parameter int Capacity = smas_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  smas_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output smas_pkg::result_t result
);
    import smas_pkg::*;

    localparam int CntW = $clog2(Capacity + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic [CntW-1:0]     count_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic [MAC_W-1:0]    key_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic [CntW-1:0]        count_next;
    logic [COUNT_OUT_W-1:0] count_out;
    logic                   full;
    logic                   found;
    logic                   exec_go;
    logic                   do_insert;
    cell_ctl_t              ctl;

    logic [Capacity-1:0]  le_vec;
    logic [Capacity-1:0]  eq_vec;
    logic [MAC_W-1:0]     entry_vec [Capacity];

    // Cell chain.
    for (genvar i = 0; i < Capacity; i++)
    begin : g_cell
        logic             cell_valid;
        logic             cell_prev_le;
        logic [MAC_W-1:0] cell_prev_entry;

        assign cell_valid = CntW'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign cell_prev_le    = 1'b1;
            assign cell_prev_entry = ctl.key;
        end
        else
        begin : g_rest
            assign cell_prev_le    = le_vec[i-1];
            assign cell_prev_entry = entry_vec[i-1];
        end

        smas_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .valid      (cell_valid),
            .prev_le    (cell_prev_le),
            .prev_entry (cell_prev_entry),
            .le         (le_vec[i]),
            .eq         (eq_vec[i]),
            .entry      (entry_vec[i])
        );
    end

    // The key is stored if any valid cell matches it.
    assign found = |eq_vec;
    assign full  = (count_reg == CntW'(Capacity));

    // Execute once the result register can take the answer.
    assign exec_go   = (state_reg == ST_EXEC) && (!result_valid_reg || !result_stall);
    assign do_insert = exec_go && (op_reg == OP_INSERT) && !full;

    assign ctl.shift_en = do_insert;
    assign ctl.key      = key_reg;

    // Entry count after the item.
    always_comb
    begin
        count_next = count_reg;
        if (exec_go)
        begin
            if (op_reg == OP_CLEAR)
            begin
                count_next = '0;
            end
            else if (do_insert)
            begin
                count_next = count_reg + CntW'(1);
            end
        end
    end

    // Count on the result port, fitted to the field width.
    if (CntW >= COUNT_OUT_W)
    begin : g_cnt_trunc
        assign count_out = count_next[COUNT_OUT_W-1:0];
    end
    else
    begin : g_cnt_ext
        assign count_out = {{(COUNT_OUT_W - CntW){1'b0}}, count_next};
    end

    // Sequencer, count and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            op_reg           <= OP_LOOKUP;
            key_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            count_reg <= count_next;
            // A new result replaces the old one; otherwise a taken result clears.
            if (exec_go)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        op_reg    <= item.opcode;
                        key_reg   <= item.mac_address;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_go)
                    begin
                        result_reg.found       <= found;
                        result_reg.status      <= ((op_reg == OP_INSERT) && full) ?
                                                  STATUS_FULL : STATUS_DONE;
                        result_reg.entry_count <= count_out;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The count never runs past the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Capacity))
        else $error("entry count exceeds capacity");

    // A new result only appears after an execute step.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result raised without an execute step");

    // A rejected insert leaves the count unchanged.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (op_reg == OP_INSERT) && full) |=> (count_reg == $past(count_reg)))
        else $error("rejected insert changed the count");

    // A clear empties the table.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (op_reg == OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

endmodule
